### hw/rtl/skin_influence_top4_quantize_defines.svh
// Assertion macros shared by the checker of the influence quantizer.
`ifndef SKIN_INFLUENCE_TOP4_QUANTIZE_DEFINES_SVH
`define SKIN_INFLUENCE_TOP4_QUANTIZE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/siq_pkg.sv
// Package of the influence quantizer: sizes, widths and controller/datapath interfaces.
package siq_pkg;

  // Number of kept influences per vertex and number of emitted slots.
  localparam int KEPT_COUNT = 4;
  localparam int OUT_SLOTS  = 4;

  // Field and accumulator widths.
  localparam int DATA_W  = 16;
  localparam int TOTAL_W = 32;
  localparam int SUM_W   = DATA_W + $clog2(KEPT_COUNT);
  localparam int SLOT_W  = (KEPT_COUNT > 1) ? $clog2(KEPT_COUNT) : 1;
  localparam int IDX_W   = $clog2(KEPT_COUNT + 1);
  localparam int STEP_W  = $clog2(DATA_W);

  // Divider operand widths: denominator is twice the 32-bit total.
  localparam int DEN_W = TOTAL_W + 1;
  localparam int NUM_W = DEN_W + DATA_W;

  localparam logic [DATA_W-1:0] UNORM_ONE = {DATA_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             take;
    logic             sort;
    logic             div_load;
    logic             div_step;
    logic             div_store;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } siq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sum_zero;
    logic out_free;
  } siq_sts_t;

endpackage

### hw/rtl/siq_ctrl.sv
// Controller of the influence quantizer: sequences accept, sort, divisions and output.
module siq_ctrl
  import siq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last_of_vertex,
  output logic     in_stall,
  input  siq_sts_t sts,
  output siq_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SORT  = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_STORE = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(KEPT_COUNT);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Input transactions are taken only while idle.
  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    cmd           = '0;
    cmd.idx       = idx_r;
    case (state_r)
      ST_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && in_last_of_vertex) begin
          state_nxt = ST_SORT;
        end
      end
      ST_SORT: begin
        cmd.sort  = 1'b1;
        idx_nxt   = '0;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.sum_zero) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.div_load = 1'b1;
          step_nxt     = '0;
          state_nxt    = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.div_store = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_OUT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

### hw/rtl/siq_dp.sv
// Datapath of the influence quantizer: kept slots, sort, shared divider and output register.
module siq_dp
  import siq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  siq_cmd_t          cmd,
  output siq_sts_t          sts,
  input  logic [DATA_W-1:0] in_joint_entry,
  input  logic [DATA_W-1:0] in_influence_weight,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_joint [OUT_SLOTS],
  output logic [DATA_W-1:0] out_weight [OUT_SLOTS],
  output logic [DATA_W-1:0] out_dropped_share
);

  // Per-vertex accumulation state.
  logic [DATA_W-1:0]  kept_j_r [KEPT_COUNT];
  logic [DATA_W-1:0]  kept_w_r [KEPT_COUNT];
  logic [TOTAL_W-1:0] total_r;

  // Finishing state.
  logic [DATA_W-1:0]  sorted_j_r [KEPT_COUNT];
  logic [DATA_W-1:0]  sorted_w_r [KEPT_COUNT];
  logic [DATA_W-1:0]  q_r [KEPT_COUNT];
  logic [SUM_W-1:0]   sum_r;
  logic [TOTAL_W-1:0] tot_r;
  logic [TOTAL_W-1:0] rest_r;
  logic               zero_r;
  logic [DATA_W-1:0]  qsum_r;
  logic [DATA_W-1:0]  drop_r;

  // Divider registers; the low word shifts out numerator bits and fills with quotient bits.
  logic [DEN_W-1:0]  rem_r;
  logic [DATA_W-1:0] lo_r;
  logic [DEN_W-1:0]  den_r;

  // Output register.
  logic              out_valid_r;
  logic [DATA_W-1:0] out_j_r [OUT_SLOTS];
  logic [DATA_W-1:0] out_w_r [OUT_SLOTS];
  logic [DATA_W-1:0] out_drop_r;

  logic [SLOT_W-1:0]  small_c;
  logic               replace_c;
  logic [TOTAL_W:0]   tsum_c;
  logic [TOTAL_W-1:0] total_nxt;
  logic [SUM_W-1:0]   sum_c;
  logic [SLOT_W-1:0]  rank_c [KEPT_COUNT];
  logic [DATA_W-1:0]  wsel_c;
  logic [NUM_W-1:0]   num_c;
  logic [DEN_W-1:0]   den_c;
  logic [DEN_W:0]     trial_c;
  logic               ge_c;
  logic [DATA_W-1:0]  j_src [OUT_SLOTS];
  logic [DATA_W-1:0]  w_src [OUT_SLOTS];

  // First slot holding the smallest kept weight, and the saturating total.
  always_comb begin
    small_c = '0;
    for (int i = 1; i < KEPT_COUNT; i++) begin
      if (kept_w_r[i] < kept_w_r[small_c]) begin
        small_c = SLOT_W'(i);
      end
    end
    replace_c = (in_influence_weight > kept_w_r[small_c]);
    tsum_c    = {1'b0, total_r} + (TOTAL_W + 1)'(in_influence_weight);
    total_nxt = tsum_c[TOTAL_W] ? {TOTAL_W{1'b1}} : tsum_c[TOTAL_W-1:0];
  end

  // Kept sum and stable descending rank of every slot.
  always_comb begin
    int cnt;
    sum_c = '0;
    for (int i = 0; i < KEPT_COUNT; i++) begin
      sum_c = sum_c + SUM_W'(kept_w_r[i]);
    end
    for (int i = 0; i < KEPT_COUNT; i++) begin
      cnt = 0;
      for (int j = 0; j < KEPT_COUNT; j++) begin
        if ((j != i) && ((kept_w_r[j] > kept_w_r[i]) ||
            ((kept_w_r[j] == kept_w_r[i]) && (j < i)))) begin
          cnt = cnt + 1;
        end
      end
      rank_c[i] = SLOT_W'(cnt);
    end
  end

  // Divider operands: a kept weight over the kept sum, or the dropped part over the total.
  // Both are rounded half up by dividing (2*x*65535 + d) by 2*d.
  always_comb begin
    wsel_c = sorted_w_r[cmd.idx[SLOT_W-1:0]];
    if (cmd.idx == IDX_W'(KEPT_COUNT)) begin
      num_c = (NUM_W'(rest_r) << (DATA_W + 1)) - (NUM_W'(rest_r) << 1) + NUM_W'(tot_r);
      den_c = {tot_r, 1'b0};
    end else begin
      num_c = (NUM_W'(wsel_c) << (DATA_W + 1)) - (NUM_W'(wsel_c) << 1) + NUM_W'(sum_r);
      den_c = DEN_W'({sum_r, 1'b0});
    end
  end

  // One restoring division step.
  always_comb begin
    trial_c = {rem_r, lo_r[DATA_W-1]};
    ge_c    = (trial_c >= {1'b0, den_r});
  end

  // Output sources; slots past the kept count stay zero.
  generate
    for (genvar p = 0; p < OUT_SLOTS; p++) begin : g_src
      if (p < KEPT_COUNT) begin : g_kept
        assign j_src[p] = sorted_j_r[p];
        if (p == 0) begin : g_first
          assign w_src[p] = q_r[p] + UNORM_ONE - qsum_r;
        end else begin : g_rest
          assign w_src[p] = q_r[p];
        end
      end else begin : g_none
        assign j_src[p] = '0;
        assign w_src[p] = '0;
      end
    end
  endgenerate

  // Accumulation state and output valid; all cleared at reset, the accumulation state also after each vertex.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEPT_COUNT; i++) begin
        kept_j_r[i] <= '0;
        kept_w_r[i] <= '0;
      end
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take) begin
        total_r <= total_nxt;
        if (replace_c) begin
          kept_w_r[small_c] <= in_influence_weight;
          kept_j_r[small_c] <= in_joint_entry;
        end
      end else if (cmd.sort) begin
        for (int i = 0; i < KEPT_COUNT; i++) begin
          kept_j_r[i] <= '0;
          kept_w_r[i] <= '0;
        end
        total_r <= '0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Finishing datapath: sort, divider and output payload.
  always_ff @(posedge clk) begin
    if (cmd.sort) begin
      for (int i = 0; i < KEPT_COUNT; i++) begin
        sorted_j_r[rank_c[i]] <= kept_j_r[i];
        sorted_w_r[rank_c[i]] <= kept_w_r[i];
      end
      sum_r  <= sum_c;
      tot_r  <= total_r;
      rest_r <= total_r - TOTAL_W'(sum_c);
      zero_r <= (sum_c == '0);
      qsum_r <= '0;
    end
    if (cmd.div_load) begin
      rem_r <= num_c[NUM_W-1:DATA_W];
      lo_r  <= num_c[DATA_W-1:0];
      den_r <= den_c;
    end else if (cmd.div_step) begin
      rem_r <= ge_c ? DEN_W'(trial_c - {1'b0, den_r}) : trial_c[DEN_W-1:0];
      lo_r  <= {lo_r[DATA_W-2:0], ge_c};
    end
    if (cmd.div_store) begin
      if (cmd.idx == IDX_W'(KEPT_COUNT)) begin
        drop_r <= lo_r;
      end else begin
        q_r[cmd.idx[SLOT_W-1:0]] <= lo_r;
        qsum_r <= qsum_r + lo_r;
      end
    end
    if (cmd.out_load) begin
      for (int p = 0; p < OUT_SLOTS; p++) begin
        out_j_r[p] <= zero_r ? '0 : j_src[p];
        out_w_r[p] <= zero_r ? '0 : w_src[p];
      end
      out_drop_r <= zero_r ? '0 : drop_r;
    end
  end

  assign sts.sum_zero = zero_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_joint         = out_j_r;
  assign out_weight        = out_w_r;
  assign out_dropped_share = out_drop_r;

endmodule

### hw/rtl/skin_influence_top4_quantize.sv
// Top level of the influence quantizer: controller and datapath.
//
// Input channel: one bone influence per transaction (joint, unorm16 weight, last flag).
// Output channel: one result per vertex, issued for the transaction marked last:
// the four heaviest joints in descending weight order, their weights normalised
// to total 65535, and the unorm16 share of the total weight that was dropped.
// An unmarked influence is taken without stalling and the block is ready again at once.
// A marked influence stalls the input while the vertex is finished: a sort,
// then five divisions on one shared 16-step restoring divider, each one a load,
// the division steps and a store, and then the result is registered; a vertex
// whose kept weights sum to zero skips the divisions. The divider sets the rate.
// The result sits in an output register; while the receiver stalls it holds, the
// next vertex's influences are still accepted, and only the next finish waits.
// Reset clears the kept slots, the running total and the output valid.
module skin_influence_top4_quantize
  import siq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] in_joint_entry,
  input  logic [DATA_W-1:0] in_influence_weight,
  input  logic              in_last_of_vertex,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_joint_0,
  output logic [DATA_W-1:0] out_joint_1,
  output logic [DATA_W-1:0] out_joint_2,
  output logic [DATA_W-1:0] out_joint_3,
  output logic [DATA_W-1:0] out_weight_0,
  output logic [DATA_W-1:0] out_weight_1,
  output logic [DATA_W-1:0] out_weight_2,
  output logic [DATA_W-1:0] out_weight_3,
  output logic [DATA_W-1:0] out_dropped_share
);

  siq_cmd_t          cmd;
  siq_sts_t          sts;
  logic [DATA_W-1:0] joint [OUT_SLOTS];
  logic [DATA_W-1:0] weight [OUT_SLOTS];

  // Sequencing of each transaction and each vertex finish.
  siq_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_last_of_vertex (in_last_of_vertex),
    .in_stall          (in_stall),
    .sts               (sts),
    .cmd               (cmd)
  );

  // Slots, sort, divider and output register.
  siq_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_joint_entry      (in_joint_entry),
    .in_influence_weight (in_influence_weight),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_joint           (joint),
    .out_weight          (weight),
    .out_dropped_share   (out_dropped_share)
  );

  assign out_joint_0  = joint[0];
  assign out_joint_1  = joint[1];
  assign out_joint_2  = joint[2];
  assign out_joint_3  = joint[3];
  assign out_weight_0 = weight[0];
  assign out_weight_1 = weight[1];
  assign out_weight_2 = weight[2];
  assign out_weight_3 = weight[3];

endmodule

### hw/rtl/siq_checker.sv
// Port checker of the influence quantizer and its bind to the top level.
`include "skin_influence_top4_quantize_defines.svh"

module siq_checker
  import siq_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [DATA_W-1:0] in_joint_entry,
  input logic [DATA_W-1:0] in_influence_weight,
  input logic              in_last_of_vertex,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] out_joint_0,
  input logic [DATA_W-1:0] out_joint_1,
  input logic [DATA_W-1:0] out_joint_2,
  input logic [DATA_W-1:0] out_joint_3,
  input logic [DATA_W-1:0] out_weight_0,
  input logic [DATA_W-1:0] out_weight_1,
  input logic [DATA_W-1:0] out_weight_2,
  input logic [DATA_W-1:0] out_weight_3,
  input logic [DATA_W-1:0] out_dropped_share
);

  logic [9*DATA_W-1:0] out_bus;
  logic [DATA_W-1:0]   wsum;
  logic                w_zero;
  logic                j_zero;
  logic                last_taken;
  logic                sum_ok;

  // Derived views of the result transaction.
  assign out_bus = {out_joint_0, out_joint_1, out_joint_2, out_joint_3, out_weight_0,
                    out_weight_1, out_weight_2, out_weight_3, out_dropped_share};
  assign wsum    = out_weight_0 + out_weight_1 + out_weight_2 + out_weight_3;
  assign w_zero  = (out_weight_0 == '0) && (out_weight_1 == '0) &&
                   (out_weight_2 == '0) && (out_weight_3 == '0);
  assign j_zero  = (out_joint_0 == '0) && (out_joint_1 == '0) &&
                   (out_joint_2 == '0) && (out_joint_3 == '0);
  assign last_taken = in_valid && !in_stall && in_last_of_vertex;
  assign sum_ok  = (KEPT_COUNT > OUT_SLOTS) || w_zero || (wsum == UNORM_ONE);

  // A stalled result holds its payload.
  `SIQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_bus), "stalled result changed")

  // The last influence of a vertex starts a finish that stalls the input.
  `SIQ_ASSERT_NEXT(a_finish_busy, clk, rst_n, last_taken, in_stall, "input not stalled during finish")

  // Emitted weights add up to one, unless the vertex had no kept weight.
  `SIQ_ASSERT_NOW(a_weight_sum, clk, rst_n, out_valid, sum_ok, "weights do not total 65535")

  // An all-zero weight result is the empty vertex, with zero joints and dropped share.
  `SIQ_ASSERT_NOW(a_empty_vertex, clk, rst_n, out_valid && w_zero, j_zero && (out_dropped_share == '0), "empty vertex result not cleared")

endmodule

bind skin_influence_top4_quantize siq_checker u_siq_checker (.*);
